// File: sv/utf8v_pkg.sv
package utf8v_pkg;

  localparam logic [7:0] CTRL_LIMIT        = 8'd32;
  localparam logic [7:0] ASCII_LIMIT       = 8'h80;
  localparam logic [7:0] CONT_MASK         = 8'hC0;
  localparam logic [7:0] CONT_MATCH        = 8'h80;
  localparam logic [7:0] LEAD2_MASK        = 8'hE0;
  localparam logic [7:0] LEAD2_MATCH       = 8'hC0;
  localparam logic [7:0] LEAD3_MASK        = 8'hF0;
  localparam logic [7:0] LEAD3_MATCH       = 8'hE0;
  localparam logic [7:0] LEAD4_MASK        = 8'hF8;
  localparam logic [7:0] LEAD4_MATCH       = 8'hF0;
  localparam logic [7:0] COUNT_MAX         = 8'hFF;
  localparam logic [7:0] NAME_BYTES_RESET  = 8'd63;
  localparam logic [7:0] CODE_POINTS_RESET = 8'd20;

  localparam logic REG_MAX_NAME_BYTES  = 1'b0;
  localparam logic REG_MAX_CODE_POINTS = 1'b1;

  typedef struct packed {
    logic [1:0] extra;
    logic       bad_lead;
    logic       is_cont;
  } lead_class_t;

  typedef struct packed {
    logic [7:0] max_name_bytes;
    logic [7:0] max_code_points;
  } limits_t;

endpackage

// File: sv/utf8v_lead_class.sv
module utf8v_lead_class
  import utf8v_pkg::*;
(
  input  logic [7:0]  data_byte,
  output lead_class_t cls
);

  always_comb begin
    cls.is_cont  = (data_byte & CONT_MASK) == CONT_MATCH;
    cls.extra    = 2'd0;
    cls.bad_lead = 1'b0;
    if (data_byte < ASCII_LIMIT) begin
      cls.bad_lead = data_byte < CTRL_LIMIT;
    end else if ((data_byte & LEAD2_MASK) == LEAD2_MATCH) begin
      cls.extra = 2'd1;
    end else if ((data_byte & LEAD3_MASK) == LEAD3_MATCH) begin
      cls.extra = 2'd2;
    end else if ((data_byte & LEAD4_MASK) == LEAD4_MATCH) begin
      cls.extra = 2'd3;
    end else begin
      cls.bad_lead = 1'b1;
    end
  end

endmodule

// File: sv/utf8v_name_state.sv
module utf8v_name_state
  import utf8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        last,
  input  lead_class_t cls,
  input  limits_t     limits,
  output logic        ok
);

  logic [1:0] pending;
  logic [7:0] byte_count;
  logic [7:0] cp_count;
  logic       error_seen;

  logic [1:0] pending_next;
  logic [7:0] byte_count_next;
  logic [7:0] cp_count_next;
  logic       error_seen_next;

  always_comb begin
    error_seen_next = error_seen;
    pending_next    = pending;
    cp_count_next   = cp_count;
    byte_count_next = byte_count;

    if (byte_count == COUNT_MAX) begin
      error_seen_next = 1'b1;
    end else begin
      byte_count_next = byte_count + 8'd1;
    end

    if (pending != 2'd0) begin
      if (!cls.is_cont) begin
        error_seen_next = 1'b1;
      end
      pending_next = pending - 2'd1;
    end else if (cls.bad_lead) begin
      error_seen_next = 1'b1;
    end else begin
      pending_next = cls.extra;
      if (cp_count == COUNT_MAX) begin
        error_seen_next = 1'b1;
      end else begin
        cp_count_next = cp_count + 8'd1;
      end
    end

    ok = !error_seen_next && (pending_next == 2'd0)
      && (byte_count_next <= limits.max_name_bytes)
      && (cp_count_next != 8'd0)
      && (cp_count_next <= limits.max_code_points);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 2'd0;
      byte_count <= 8'd0;
      cp_count   <= 8'd0;
      error_seen <= 1'b0;
    end else if (advance) begin
      if (last) begin
        pending    <= 2'd0;
        byte_count <= 8'd0;
        cp_count   <= 8'd0;
        error_seen <= 1'b0;
      end else begin
        pending    <= pending_next;
        byte_count <= byte_count_next;
        cp_count   <= cp_count_next;
        error_seen <= error_seen_next;
      end
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> pending == 2'd0 && byte_count == 8'd0
      && cp_count == 8'd0 && !error_seen)
    else $error("name state not cleared after final byte");

  a_cp_le_bytes: assert property (@(posedge clk) disable iff (rst)
    cp_count <= byte_count)
    else $error("code point count exceeds byte count");

  a_pending_has_lead: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd0 |-> cp_count != 8'd0)
    else $error("continuations pending without a lead byte");
`endif

endmodule

// File: sv/utf8_name_validator.sv
// Result path: after the final byte's transaction, the input register and then the result
// register are loaded before m_tvalid rises.
// Throughput: one byte per cycle; the input register, per-byte state update and
// result register form a single pass, stalled only when a result waits on m_tready.
// Reset (rst, synchronous): clears all name state and the valid bits of both pipeline
// registers, and loads max_name_bytes = 63, max_code_points = 20.
module utf8_name_validator
  import utf8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_name
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] name_ok, [7:1] zero
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_data
);

  limits_t     limits;
  logic        in_vld;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  logic        ok;
  logic        out_vld;
  logic        out_ok;
  lead_class_t cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_name_bytes  <= NAME_BYTES_RESET;
      limits.max_code_points <= CODE_POINTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_NAME_BYTES:  limits.max_name_bytes  <= cfg_data;
        REG_MAX_CODE_POINTS: limits.max_code_points <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_vld && (!in_last || !out_vld || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  utf8v_lead_class u_class (
    .data_byte (in_byte),
    .cls       (cls)
  );

  utf8v_name_state u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .last    (in_last),
    .cls     (cls),
    .limits  (limits),
    .ok      (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && in_last) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_ok <= ok;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'd0, out_ok};

`ifndef SYNTH
  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    in_vld && !advance |-> in_last && out_vld && !m_tready)
    else $error("input stage stalled without a waiting result");
`endif

endmodule
